// File: design/lcdw_pkg.sv
// Shared types and constants of the LCD decimal number writer.
package lcdw_pkg;

    // Input number and its decimal form
    localparam int NUMBER_W      = 16;
    localparam int DIGITS        = 5;
    localparam int DIGIT_W       = 4;
    localparam int BCD_W         = DIGITS * DIGIT_W;
    localparam int DIGIT_IDX_W   = 3;
    localparam int COL_W         = 4;

    // Binary-to-BCD pipeline: two shift steps per stage
    localparam int STEPS_PER_STAGE = 2;
    localparam int NUM_STAGES      = NUMBER_W / STEPS_PER_STAGE;

    // Display bus codes
    localparam logic [7:0] LINE0_BASE = 8'h80;
    localparam logic [7:0] LINE1_BASE = 8'hC0;
    localparam logic [7:0] ASCII_ZERO = 8'd48;

    // Index of the units digit
    localparam logic [DIGIT_IDX_W-1:0] UNITS_IDX = DIGIT_IDX_W'(DIGITS - 1);

    // One classified number, passed from the front end to the write sequencer
    typedef struct packed {
        logic [DIGITS-1:0][DIGIT_W-1:0] digits;    // digits[0] is ten-thousands
        logic [DIGIT_IDX_W-1:0]         first_idx; // first digit that is printed
        logic [COL_W-1:0]               col;
        logic                           line;
    } lcdw_job_t;

endpackage

// File: design/lcdw_front.sv
// Front end: accepts numbers and converts them to decimal digits in a pipeline.
module lcdw_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lcdw_pkg::COL_W-1:0]    in_col,
    input  logic                          in_line,
    input  logic [lcdw_pkg::NUMBER_W-1:0] in_number,
    output logic                          job_valid,
    input  logic                          job_ready,
    output lcdw_pkg::lcdw_job_t           job_data
);

    localparam int LAST_STAGE = lcdw_pkg::NUM_STAGES - 1;

    typedef struct packed {
        logic [lcdw_pkg::BCD_W-1:0]    bcd;
        logic [lcdw_pkg::NUMBER_W-1:0] bin;
    } conv_t;

    // Double-dabble stage: per step, correct each digit, then shift one binary bit in
    function automatic conv_t dd_step(conv_t c);
        conv_t r;
        int    i;
        int    d;
        r = c;
        for (i = 0; i < lcdw_pkg::STEPS_PER_STAGE; i++) begin
            for (d = 0; d < lcdw_pkg::DIGITS; d++) begin
                if (r.bcd[d*lcdw_pkg::DIGIT_W +: lcdw_pkg::DIGIT_W] >= 4'd5) begin
                    r.bcd[d*lcdw_pkg::DIGIT_W +: lcdw_pkg::DIGIT_W] =
                        r.bcd[d*lcdw_pkg::DIGIT_W +: lcdw_pkg::DIGIT_W] + 4'd3;
                end
            end
            r = r << 1;
        end
        return r;
    endfunction

    logic                          valid_reg [lcdw_pkg::NUM_STAGES];
    conv_t                         conv_reg  [lcdw_pkg::NUM_STAGES];
    logic [lcdw_pkg::COL_W-1:0]    col_reg   [lcdw_pkg::NUM_STAGES];
    logic                          line_reg  [lcdw_pkg::NUM_STAGES];
    logic                          advance;
    conv_t                         conv_in;

    // Move the whole pipeline when its tail is empty or taken by the queue
    assign advance  = !valid_reg[LAST_STAGE] || job_ready;
    assign in_ready = advance;

    always_comb begin
        conv_in.bcd = '0;
        conv_in.bin = in_number;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < lcdw_pkg::NUM_STAGES; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (advance) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < lcdw_pkg::NUM_STAGES; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Conversion payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            conv_reg[0] <= dd_step(conv_in);
            col_reg[0]  <= in_col;
            line_reg[0] <= in_line;
            for (int k = 1; k < lcdw_pkg::NUM_STAGES; k++) begin
                conv_reg[k] <= dd_step(conv_reg[k-1]);
                col_reg[k]  <= col_reg[k-1];
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    // Classify: split digits and find the first one to print
    always_comb begin
        job_data.col  = col_reg[LAST_STAGE];
        job_data.line = line_reg[LAST_STAGE];
        for (int d = 0; d < lcdw_pkg::DIGITS; d++) begin
            job_data.digits[d] = conv_reg[LAST_STAGE].bcd[
                (lcdw_pkg::DIGITS-1-d)*lcdw_pkg::DIGIT_W +: lcdw_pkg::DIGIT_W];
        end
        priority if (job_data.digits[0] != '0) begin
            job_data.first_idx = 3'd0;
        end else if (job_data.digits[1] != '0) begin
            job_data.first_idx = 3'd1;
        end else if (job_data.digits[2] != '0) begin
            job_data.first_idx = 3'd2;
        end else if (job_data.digits[3] != '0) begin
            job_data.first_idx = 3'd3;
        end else begin
            job_data.first_idx = lcdw_pkg::UNITS_IDX;
        end
    end

    assign job_valid = valid_reg[LAST_STAGE];

endmodule

// File: design/lcdw_queue.sv
// Short job queue between the conversion front end and the write sequencer.
module lcdw_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  lcdw_pkg::lcdw_job_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output lcdw_pkg::lcdw_job_t rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    lcdw_pkg::lcdw_job_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                push;
    logic                pop;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers with wrap and track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: design/lcdw_back.sv
// Write sequencer: turns each job into cursor and character bus writes.
module lcdw_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  lcdw_pkg::lcdw_job_t job_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMD  = 3'b010,
        ST_DATA = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    lcdw_pkg::lcdw_job_t                 job_reg, job_next;
    logic [lcdw_pkg::DIGIT_IDX_W-1:0]    idx_reg, idx_next;
    logic                                out_valid_reg, out_valid_next;
    logic [7:0]                          out_byte_reg, out_byte_next;
    logic                                out_data_reg, out_data_next;
    logic                                out_last_reg, out_last_next;
    logic                                out_load;
    logic                                is_units;
    logic [lcdw_pkg::DIGIT_IDX_W-1:0]    offset;
    logic [7:0]                          line_base;
    logic [7:0]                          cursor_addr;
    logic [7:0]                          char_code;

    assign out_load = !out_valid_reg || m_tready;
    assign is_units = idx_reg == lcdw_pkg::UNITS_IDX;

    // Form cursor address and ASCII digit of the current position
    assign offset      = idx_reg - job_reg.first_idx;
    assign line_base   = job_reg.line ? lcdw_pkg::LINE1_BASE : lcdw_pkg::LINE0_BASE;
    assign cursor_addr = line_base + {4'b0, job_reg.col} + {5'b0, offset};
    assign char_code   = lcdw_pkg::ASCII_ZERO + {4'b0, job_reg.digits[idx_reg]};

    // Take a new job when idle or as the units write of the current one is loaded for output
    assign job_ready = (state_reg == ST_IDLE) ||
                       (state_reg == ST_DATA && out_load && is_units);

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_load ? 1'b0 : out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = ST_CMD;
                    job_next   = job_data;
                    idx_next   = job_data.first_idx;
                end
            end
            ST_CMD: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cursor_addr;
                    out_data_next  = 1'b0;
                    out_last_next  = 1'b0;
                    state_next     = ST_DATA;
                end
            end
            ST_DATA: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = char_code;
                    out_data_next  = 1'b1;
                    out_last_next  = is_units;
                    if (!is_units) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_CMD;
                    end else if (job_valid) begin
                        job_next   = job_data;
                        idx_next   = job_data.first_idx;
                        state_next = ST_CMD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: job, position and output register
    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: design/lcd_decimal_number_writer_unit.sv
// Top level of the LCD decimal number writer.
// Each input transaction carries a 16-bit unsigned number, a start column and a
// display line. The number goes through an eight-stage binary-to-decimal
// pipeline (two bits per stage) that accepts one transaction per clock unless a
// full queue holds its tail, then waits in a short job queue (QUEUE_DEPTH
// entries, at least 2) for the write sequencer. The sequencer drops leading
// zeros (zero prints as "0") and sends two output transactions per printed
// digit: a cursor address command (tuser 0, 0x80 or 0xC0 plus column plus digit
// offset) and the ASCII digit (tuser 1), with tlast on the units digit. A number
// thus occupies the output for 2 to 10 bus writes, one bus write per cycle while
// the receiver is ready, and that output rate sets the sustained throughput. The
// front end keeps accepting while the output is stalled until the queue is full
// and the pipeline tail holds a job. No clearing pass is needed after reset.
module lcd_decimal_number_writer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] start_column, [19:4] number, [23:20] zero
    input  logic [0:0]  s_tuser,   // [0] line_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] bus_byte
    output logic [0:0]  m_tuser,   // [0] is_data
    output logic        m_tlast
);

    logic                q_wr_valid;
    logic                q_wr_ready;
    lcdw_pkg::lcdw_job_t q_wr_data;
    logic                q_rd_valid;
    logic                q_rd_ready;
    lcdw_pkg::lcdw_job_t q_rd_data;

    lcdw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_col    (s_tdata[3:0]),
        .in_line   (s_tuser[0]),
        .in_number (s_tdata[19:4]),
        .job_valid (q_wr_valid),
        .job_ready (q_wr_ready),
        .job_data  (q_wr_data)
    );

    lcdw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    lcdw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_rd_valid),
        .job_ready (q_rd_ready),
        .job_data  (q_rd_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser[0]),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // Frame end only on a character write
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("tlast on a cursor command");

    // Cursor commands always carry the set-address bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[7])
        else $error("cursor command without address bit");

    // Character writes are decimal digits only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata >= 8'd48) && (m_tdata <= 8'd57))
        else $error("character write is not a decimal digit");

    // A command is always followed by its character write
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser[0] |=> m_tvalid && m_tuser[0])
        else $error("cursor command not followed by a character");
`endif

endmodule

// File: dv/testbench.sv
// Testbench for the LCD decimal number writer: stream stimulus, digit prediction, write check.
`timescale 1ns / 100ps

module testbench;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 30;
    localparam int STALL_LIMIT    = 5000;
    localparam int PHASE_ITEMS    = 90;

    // One number to print
    typedef struct {
        logic [lcdw_pkg::COL_W-1:0]    col;
        logic                          line;
        logic [lcdw_pkg::NUMBER_W-1:0] number;
    } lcd_number_t;

    // One display bus write
    typedef struct {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } lcd_write_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [3:0] start_column, [19:4] number, [23:20] zero
    logic [0:0]  s_tuser  = '0;   // [0] line_select
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] bus_byte
    logic [0:0]  m_tuser;         // [0] is_data
    logic        m_tlast;

    lcd_number_t numbers_pending[$];
    lcd_write_t  bus_writes_due[$];

    int  numbers_sent   = 0;
    int  numbers_taken  = 0;
    int  mismatches     = 0;
    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    bit  holdoff_armed  = 1'b0;
    bit  in_taken       = 1'b0;

    lcd_decimal_number_writer_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Split the number into decimal digits, drop leading zeros and queue the writes
    function automatic void queue_lcd_writes(input logic [lcdw_pkg::COL_W-1:0] col,
                                             input logic line,
                                             input logic [lcdw_pkg::NUMBER_W-1:0] number);
        int unsigned rest;
        int unsigned digit_val[lcdw_pkg::DIGITS];
        int          lead;
        logic [7:0]  addr_base;
        lcd_write_t  w;
        rest = number;
        for (int i = lcdw_pkg::DIGITS - 1; i >= 0; i--) begin
            digit_val[i] = rest % 10;
            rest = rest / 10;
        end
        lead = 0;
        while (lead < lcdw_pkg::DIGITS - 1 && digit_val[lead] == 0)
            lead++;
        addr_base = line ? lcdw_pkg::LINE1_BASE : lcdw_pkg::LINE0_BASE;
        for (int d = lead; d < lcdw_pkg::DIGITS; d++) begin
            w.is_data  = 1'b0;
            w.bus_byte = 8'(addr_base + col + (d - lead));
            w.last     = 1'b0;
            bus_writes_due.push_back(w);
            w.is_data  = 1'b1;
            w.bus_byte = 8'(lcdw_pkg::ASCII_ZERO + digit_val[d]);
            w.last     = (d == lcdw_pkg::DIGITS - 1);
            bus_writes_due.push_back(w);
        end
    endfunction

    function automatic void add_number(input logic [lcdw_pkg::COL_W-1:0] col, input logic line,
                                       input logic [lcdw_pkg::NUMBER_W-1:0] number);
        lcd_number_t n;
        n.col    = col;
        n.line   = line;
        n.number = number;
        numbers_pending.push_back(n);
        numbers_sent++;
    endfunction

    // Hold until every number is taken and every write has come out
    task automatic drain_all();
        while (numbers_taken < numbers_sent) @(posedge aclk);
        while (bus_writes_due.size() > 0) @(posedge aclk);
    endtask

    // Random numbers, weighted toward short ones so every digit count shows up
    task automatic run_random(input int count, input int idle_pct, input int stall_pct,
                              input bit holdoff);
        int unsigned top;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        holdoff_armed  = holdoff;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(5))
                0: top = 9;
                1: top = 99;
                2: top = 999;
                3: top = 9999;
                default: top = 65535;
            endcase
            add_number(lcdw_pkg::COL_W'($urandom_range(15)), 1'($urandom_range(1)),
                       lcdw_pkg::NUMBER_W'($urandom_range(top)));
        end
        drain_all();
        holdoff_armed = 1'b0;
    endtask

    // Driver: present the next number at the falling edge once the last one is taken
    always @(negedge aclk) begin : driver
        lcd_number_t nxt;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (numbers_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = numbers_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0000, nxt.number, nxt.col};
                s_tuser  <= nxt.line;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when armed
    always @(negedge aclk) begin : receiver
        static int holdoff_left = 0;
        static bit holdoff_done = 1'b0;
        if (holdoff_armed && !holdoff_done) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Monitor: predict on each input transaction, check each output transaction
    always @(posedge aclk) begin : monitor
        lcd_write_t want;
        in_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            queue_lcd_writes(s_tdata[3:0], s_tuser[0], s_tdata[19:4]);
            numbers_taken++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (bus_writes_due.size() == 0) begin
                $error("unexpected bus write: is_data %0b bus_byte 0x%02h last %0b",
                       m_tuser[0], m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = bus_writes_due.pop_front();
                if (m_tuser[0] !== want.is_data) begin
                    $error("is_data: expected %0b, got %0b", want.is_data, m_tuser[0]);
                    mismatches++;
                end
                if (m_tdata !== want.bus_byte) begin
                    $error("bus_byte: expected 0x%02h, got 0x%02h", want.bus_byte, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge aclk) begin : watchdog
        static int quiet_cycles = 0;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL lcd_decimal_number_writer_unit");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: digit-count boundaries, field extremes, both lines
        add_number(4'd0,  1'b0, 16'd0);
        add_number(4'd15, 1'b1, 16'd0);
        add_number(4'd0,  1'b1, 16'd1);
        add_number(4'd7,  1'b0, 16'd9);
        add_number(4'd3,  1'b1, 16'd10);
        add_number(4'd15, 1'b0, 16'd99);
        add_number(4'd1,  1'b0, 16'd100);
        add_number(4'd14, 1'b1, 16'd999);
        add_number(4'd2,  1'b0, 16'd1000);
        add_number(4'd12, 1'b1, 16'd9999);
        add_number(4'd0,  1'b0, 16'd10000);
        add_number(4'd15, 1'b0, 16'd65535);
        add_number(4'd15, 1'b1, 16'd65535);
        add_number(4'd5,  1'b1, 16'd10001);
        add_number(4'd9,  1'b0, 16'd50005);
        add_number(4'd10, 1'b1, 16'd32768);
        add_number(4'd6,  1'b0, 16'hAAAA);
        add_number(4'd11, 1'b1, 16'h5555);
        add_number(4'd8,  1'b0, 16'd12345);
        add_number(4'd4,  1'b1, 16'd60000);
        add_number(4'd13, 1'b0, 16'd909);
        drain_all();

        // Random phases: free flow, sender gaps, receiver stalls with hold-off, both
        run_random(PHASE_ITEMS, 0, 0, 1'b0);
        run_random(PHASE_ITEMS, 57, 0, 1'b0);
        run_random(PHASE_ITEMS, 0, 57, 1'b1);
        run_random(PHASE_ITEMS, 17, 17, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (bus_writes_due.size() != 0) begin
            $error("%0d expected bus writes never came out", bus_writes_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("PASS lcd_decimal_number_writer_unit");
        end else begin
            $display("FAIL lcd_decimal_number_writer_unit");
        end
        $finish;
    end

endmodule
